>>> hdl/thin_plate_spline_3d_eval_top_macros.svh
// Assertion macros for the thin plate spline evaluator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef THIN_PLATE_SPLINE_3D_EVAL_TOP_MACROS_SVH
`define THIN_PLATE_SPLINE_3D_EVAL_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPS3_ASSERT_SAME(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("tps3 same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TPS3_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("tps3 next-cycle check failed");

`endif

>>> hdl/tps3_pkg.sv
// Shared types and constants of the thin plate spline evaluator.
// No dependencies; every module of the design and the testbench imports it.
package tps3_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int DEF_MAX_POINTS = 64;
  localparam int IDX_FIELD_W    = 6;
  localparam int TABLE_LIMIT    = 1 << IDX_FIELD_W;
  localparam int PC_W           = 7;
  localparam int COEF_COUNT     = 12;
  localparam int RADIAL_MIN     = 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QC_W           = $clog2(QUEUE_DEPTH + 1);

  localparam int R2_SHIFT = 2 * FRAC_BITS - 2;
  localparam logic [63:0] R2_THRESH = (64'd1 << R2_SHIFT) / 64'd100000000;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  localparam int D_W     = 33;
  localparam int LN_W    = 40;
  localparam int U_W     = 56;
  localparam int U_SPLIT = 28;
  localparam int ACC_W   = 96;

  localparam logic [1:0] OP_EVAL  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_COEF  = 2'd2;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [IDX_FIELD_W-1:0] entry_index;
    logic signed [31:0]     coord_x;
    logic signed [31:0]     coord_y;
    logic signed [31:0]     coord_z;
    logic signed [31:0]     weight_x_in;
    logic signed [31:0]     weight_y_in;
    logic signed [31:0]     weight_z_in;
    logic signed [31:0]     coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mapped_x;
    logic signed [31:0] mapped_y;
    logic signed [31:0] mapped_z;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
  } cpoint_t;

  typedef struct packed {
    logic                  start;
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic signed [D_W-1:0] dz;
  } rad_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [U_W-1:0] u;
  } rad_rsp_t;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    logic [QC_W-1:0] count;
  } queue_stat_t;

endpackage

>>> hdl/tps3_front.sv
// Front end: accepts requests and drops those that have no effect.
// Depends on tps3_pkg; feeds tps3_queue.
module tps3_front import tps3_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  input  logic     q_full,
  output logic     push,
  output in_item_t push_data
);

  logic keep;

  // Evaluations always go on; loads only when their slot exists.
  always_comb begin
    case (in_data.opcode)
      OP_EVAL:  keep = 1'b1;
      OP_POINT: keep = (32'(in_data.entry_index) < MAX_POINTS);
      OP_COEF:  keep = (32'(in_data.entry_index) < COEF_COUNT);
      default:  keep = 1'b0;
    endcase
  end

  assign in_stall  = q_full;
  assign push      = in_valid && !q_full && keep;
  assign push_data = in_data;

endmodule

>>> hdl/tps3_queue.sv
// Short show-ahead queue between the front end and the back end.
// Depends on tps3_pkg.
module tps3_queue import tps3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  in_item_t    push_data,
  input  logic        pop,
  output in_item_t    head,
  output queue_stat_t stat
);

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  in_item_t        slot_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_r;
  logic [QP_W-1:0] rd_r;
  logic [QC_W-1:0] count_r;

  function automatic logic [QP_W-1:0] bump(input logic [QP_W-1:0] p);
    return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_r <= bump(wr_r);
      if (pop) rd_r <= bump(rd_r);
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_data;
  end

  assign head       = slot_r[rd_r];
  assign stat.push  = push;
  assign stat.pop   = pop;
  assign stat.full  = (count_r == QC_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule

>>> hdl/tps3_radial.sv
// Iterative radial unit: U = 0.5 * r2 * ln(r2) for one offset vector.
// Depends on tps3_pkg; used by tps3_back.
module tps3_radial import tps3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rad_req_t req,
  output rad_rsp_t rsp
);

  localparam logic [3:0] RS_IDLE = 4'd0;
  localparam logic [3:0] RS_SQ   = 4'd1;
  localparam logic [3:0] RS_CHK  = 4'd2;
  localparam logic [3:0] RS_NORM = 4'd3;
  localparam logic [3:0] RS_LOG  = 4'd4;
  localparam logic [3:0] RS_LNA  = 4'd5;
  localparam logic [3:0] RS_LNB  = 4'd6;
  localparam logic [3:0] RS_P    = 4'd7;
  localparam logic [3:0] RS_SH   = 4'd8;

  logic [3:0]            state_r;
  logic [D_W-1:0]        mag_r [3];
  logic [63:0]           racc_r;
  logic [63:0]           norm_r;
  logic [5:0]            sc_r;
  logic [4:0]            cnt_r;
  logic [31:0]           m_r;
  logic [31:0]           m0_r;
  logic [29:0]           frac_r;
  logic [59:0]           t_r;
  logic signed [LN_W-1:0] ln_r;
  logic [63:0]           p_r;
  logic                  neg_r;
  logic signed [U_W-1:0] u_r;
  logic                  done_r;

  logic [D_W-1:0]         sel_mag;
  logic [2*D_W-1:0]       sq;
  logic [6:0]             amt;
  logic                   top_zero;
  logic [63:0]            norm_nxt;
  logic [5:0]             sc_nxt;
  logic [5:0]             k;
  logic [63:0]            msq;
  logic [32:0]            mt;
  logic signed [7:0]      kd;
  logic signed [LN_W-1:0] ln_nxt;
  logic [LN_W-1:0]        ln_mag;
  logic [63:0]            p_nxt;
  logic [6:0]             sh_amt;
  logic [63:0]            uu;
  logic signed [U_W-1:0]  u_val;

  function automatic logic [D_W-1:0] magn(input logic signed [D_W-1:0] d);
    return d[D_W-1] ? D_W'(-d) : D_W'(d);
  endfunction

  always_comb begin
    sel_mag  = mag_r[cnt_r[1:0]];
    sq       = (2*D_W)'(sel_mag) * (2*D_W)'(sel_mag);
    amt      = 7'd32 >> cnt_r[2:0];
    top_zero = ((norm_r >> (7'd64 - amt)) == 64'd0);
    norm_nxt = top_zero ? (norm_r << amt) : norm_r;
    sc_nxt   = top_zero ? (sc_r + amt[5:0]) : sc_r;
    k        = 6'd63 - sc_r;
    msq      = 64'(m_r) * 64'(m_r);
    mt       = msq[63:31];
    kd       = $signed(8'(k)) - $signed(8'(R2_SHIFT));
    ln_nxt   = LN_W'(kd) * $signed({1'b0, LN2_Q30}) + $signed(LN_W'(t_r[59:30]));
    ln_mag   = ln_r[LN_W-1] ? LN_W'(-ln_r) : LN_W'(ln_r);
    p_nxt    = 64'(m0_r[31:8]) * 64'(ln_mag);
    sh_amt   = 7'(52 + FRAC_BITS) - 7'(k);
    uu       = (p_r + (64'd1 << (sh_amt - 7'd1))) >> sh_amt;
    if (sh_amt >= 7'd64) begin
      u_val = '0;
    end else begin
      u_val = neg_r ? U_W'(-uu) : U_W'(uu);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
      done_r  <= 1'b0;
    end else begin
      // The result is ready after the final shift, or at once at or below the threshold.
      done_r <= (state_r == RS_SH) || ((state_r == RS_CHK) && (racc_r <= R2_THRESH));
      case (state_r)
        RS_IDLE: begin
          if (req.start) begin
            mag_r[0] <= magn(req.dx);
            mag_r[1] <= magn(req.dy);
            mag_r[2] <= magn(req.dz);
            racc_r   <= '0;
            cnt_r    <= '0;
            state_r  <= RS_SQ;
          end
        end
        RS_SQ: begin
          racc_r <= racc_r + sq[2*D_W-1:2];
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == 5'd2) state_r <= RS_CHK;
        end
        RS_CHK: begin
          cnt_r <= '0;
          if (racc_r <= R2_THRESH) begin
            u_r     <= '0;
            state_r <= RS_IDLE;
          end else begin
            norm_r  <= racc_r;
            sc_r    <= '0;
            state_r <= RS_NORM;
          end
        end
        RS_NORM: begin
          norm_r <= norm_nxt;
          sc_r   <= sc_nxt;
          if (cnt_r == 5'd5) begin
            m_r     <= norm_nxt[63:32];
            m0_r    <= norm_nxt[63:32];
            frac_r  <= '0;
            cnt_r   <= '0;
            state_r <= RS_LOG;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        RS_LOG: begin
          if (mt[32]) begin
            m_r <= mt[32:1];
            frac_r[5'd29 - cnt_r] <= 1'b1;
          end else begin
            m_r <= mt[31:0];
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd29) state_r <= RS_LNA;
        end
        RS_LNA: begin
          t_r     <= 60'(frac_r) * 60'(LN2_Q30);
          state_r <= RS_LNB;
        end
        RS_LNB: begin
          ln_r    <= ln_nxt;
          state_r <= RS_P;
        end
        RS_P: begin
          p_r     <= p_nxt;
          neg_r   <= ln_r[LN_W-1];
          state_r <= RS_SH;
        end
        RS_SH: begin
          u_r     <= u_val;
          state_r <= RS_IDLE;
        end
        default: state_r <= RS_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.u    = u_r;

endmodule

>>> hdl/tps3_back.sv
// Back end: executes queued loads and evaluations, holds the tables.
// Depends on tps3_pkg and tps3_radial.
module tps3_back import tps3_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  in_item_t        cmd,
  input  logic            cmd_avail,
  output logic            cmd_pop,
  input  logic [PC_W-1:0] point_count,
  input  logic            out_stall,
  output logic            out_valid,
  output out_item_t       out_data
);

  localparam int DEPTH = (MAX_POINTS < TABLE_LIMIT) ? MAX_POINTS : TABLE_LIMIT;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_AFF    = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_RSTART = 3'd3;
  localparam logic [2:0] ST_RWAIT  = 3'd4;
  localparam logic [2:0] ST_WMAC   = 3'd5;
  localparam logic [2:0] ST_DRAIN  = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  localparam logic [3:0] AFF_LAST  = 4'(COEF_COUNT - 1);
  localparam logic [3:0] WMAC_LAST = 4'd5;
  localparam logic signed [31:0] ONE_Q = 32'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF_Q  = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'h7fffffff);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  logic [2:0]              state_r, state_nxt;
  logic [3:0]              step_r;
  logic [CNT_W-1:0]        pt_r;
  logic signed [31:0]      qx_r, qy_r, qz_r;
  logic signed [31:0]      coef_r [COEF_COUNT];
  cpoint_t                 mem [DEPTH];
  cpoint_t                 rd_r;
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [63:0]      prod_r;
  logic                    prod_vld_r;
  logic [1:0]              prod_axis_r;
  logic                    prod_sh_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [CNT_W-1:0]        n_pts;
  logic                    has_radial;
  logic                    pt_last;
  logic                    issue;
  logic [1:0]              issue_axis;
  logic                    issue_sh;
  logic signed [31:0]      mul_a, mul_b;
  logic signed [ACC_W-1:0] term;
  rad_req_t                rad_req;
  rad_rsp_t                rad_rsp;

  function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    s = (a + HALF_Q) >>> FRAC_BITS;
    if (s > SAT_MAX) return 32'h7fffffff;
    else if (s < SAT_MIN) return 32'h80000000;
    else return s[31:0];
  endfunction

  tps3_radial u_radial (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rad_req),
    .rsp   (rad_rsp)
  );

  always_comb begin
    n_pts      = (32'(point_count) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(point_count);
    has_radial = (n_pts > CNT_W'(RADIAL_MIN));
    pt_last    = (pt_r == n_pts - CNT_W'(1));
    cmd_pop    = (state_r == ST_IDLE) && cmd_avail;

    rad_req.start = (state_r == ST_RSTART);
    rad_req.dx = $signed({qx_r[31], qx_r}) - $signed({rd_r.px[31], rd_r.px});
    rad_req.dy = $signed({qy_r[31], qy_r}) - $signed({rd_r.py[31], rd_r.py});
    rad_req.dz = $signed({qz_r[31], qz_r}) - $signed({rd_r.pz[31], rd_r.pz});

    issue      = 1'b0;
    issue_axis = 2'd0;
    issue_sh   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    if (state_r == ST_AFF) begin
      issue      = 1'b1;
      issue_axis = step_r[3:2];
      mul_a      = coef_r[step_r];
      case (step_r[1:0])
        2'd1:    mul_b = qx_r;
        2'd2:    mul_b = qy_r;
        2'd3:    mul_b = qz_r;
        default: mul_b = ONE_Q;
      endcase
    end else if (state_r == ST_WMAC) begin
      issue      = 1'b1;
      issue_axis = step_r[2:1];
      issue_sh   = !step_r[0];
      // The radial term is split so each product stays within 32 by 32 bits.
      mul_a = step_r[0] ? $signed({4'b0, rad_rsp.u[U_SPLIT-1:0]})
                        : $signed({{4{rad_rsp.u[U_W-1]}}, rad_rsp.u[U_W-1:U_SPLIT]});
      case (step_r[2:1])
        2'd1:    mul_b = rd_r.wy;
        2'd2:    mul_b = rd_r.wz;
        default: mul_b = rd_r.wx;
      endcase
    end

    term = prod_sh_r ? (ACC_W'(prod_r) <<< U_SPLIT) : ACC_W'(prod_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (cmd_avail && cmd.opcode == OP_EVAL) state_nxt = ST_AFF;
      ST_AFF:    if (step_r == AFF_LAST) state_nxt = has_radial ? ST_RD : ST_DRAIN;
      ST_RD:     state_nxt = ST_RSTART;
      ST_RSTART: state_nxt = ST_RWAIT;
      ST_RWAIT:  if (rad_rsp.done) state_nxt = ST_WMAC;
      ST_WMAC:   if (step_r == WMAC_LAST) state_nxt = pt_last ? ST_DRAIN : ST_RD;
      ST_DRAIN:  state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      pt_r        <= '0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < COEF_COUNT; i++) begin
        coef_r[i] <= (i == 1 || i == 6 || i == 11) ? ONE_Q : 32'sd0;
      end
    end else begin
      state_r    <= state_nxt;
      prod_vld_r <= issue;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (cmd_avail && cmd.opcode == OP_COEF) begin
            coef_r[cmd.entry_index[3:0]] <= cmd.coef_value;
          end
          step_r <= '0;
          pt_r   <= '0;
        end
        ST_AFF: step_r <= (step_r == AFF_LAST) ? 4'd0 : step_r + 1'b1;
        ST_WMAC: begin
          if (step_r == WMAC_LAST) begin
            step_r <= '0;
            if (!pt_last) pt_r <= pt_r + 1'b1;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_OUT: if (!out_valid_r) out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.opcode == OP_POINT) begin
      mem[cmd.entry_index[IDX_W-1:0]] <= '{px: cmd.coord_x, py: cmd.coord_y,
                                          pz: cmd.coord_z, wx: cmd.weight_x_in,
                                          wy: cmd.weight_y_in, wz: cmd.weight_z_in};
    end
    rd_r <= mem[pt_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    prod_r      <= mul_a * mul_b;
    prod_axis_r <= issue_axis;
    prod_sh_r   <= issue_sh;
    if (cmd_pop && cmd.opcode == OP_EVAL) begin
      qx_r <= cmd.coord_x;
      qy_r <= cmd.coord_y;
      qz_r <= cmd.coord_z;
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
    end else if (prod_vld_r) begin
      acc_r[prod_axis_r] <= acc_r[prod_axis_r] + term;
    end
    if (state_r == ST_OUT && !out_valid_r) begin
      out_data_r.mapped_x <= round_sat(acc_r[0]);
      out_data_r.mapped_y <= round_sat(acc_r[1]);
      out_data_r.mapped_z <= round_sat(acc_r[2]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/thin_plate_spline_3d_eval_top.sv
// Top level of the 3D thin plate spline warp evaluator.
// Depends on tps3_pkg, tps3_front, tps3_queue, tps3_back and the macro header.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_data    (in_item_t)
//   out      output     out_valid / out_stall  out_data   (out_item_t)
//   cfg      input      psel penable pwrite    paddr pwdata prdata pready
//
// A load request is written into its table when the back end pops it. An
// evaluation runs the affine part as pop, twelve products, drain and output
// register. Only when more than four control points are in use does each
// point also pass through the radial unit, which skips its logarithm when the
// query lies within the threshold distance of it; the radial unit dominates,
// with 30 serial squaring steps of its logarithm loop per point.
// Synchronous active-low reset clears control state and sets the affine
// coefficients to identity; the control point table is undefined until loaded.
// A waiting result does not block the queue; the back end stalls only when
// a new result is ready while the previous one has not yet been taken.
`include "thin_plate_spline_3d_eval_top_macros.svh"

module thin_plate_spline_3d_eval_top import tps3_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The only register, point_count, sits at byte address zero; only address bit 2 is decoded.
  logic [PC_W-1:0] point_count_r;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? 32'(point_count_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else if (cfg_write) begin
      point_count_r <= pwdata[PC_W-1:0];
    end
  end

  // The front end filters requests into the queue; the back end drains it.
  logic        q_push;
  in_item_t    q_push_data;
  logic        q_pop;
  in_item_t    q_head;
  queue_stat_t q_stat;

  tps3_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .q_full    (q_stat.full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  tps3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  tps3_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (q_head),
    .cmd_avail   (!q_stat.empty),
    .cmd_pop     (q_pop),
    .point_count (point_count_r),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  // The queue never overflows or underflows, and its count rises after a push without a pop.
  `TPS3_ASSERT_SAME(a_push_not_full, q_stat.push, !q_stat.full)
  `TPS3_ASSERT_SAME(a_pop_not_empty, q_stat.pop, !q_stat.empty)
  `TPS3_ASSERT_NEXT(a_count_up, q_stat.push && !q_stat.pop, q_stat.count == $past(q_stat.count) + 1'b1)

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the 3D thin plate spline warp evaluator.
// Depends on tps3_pkg and the top level thin_plate_spline_3d_eval_top.
module tb_top;
  import tps3_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [2:0] ADDR_POINT_COUNT = 3'd0;
  localparam int SETTLE_CYCLES = 40;
  localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;
  localparam logic [63:0] LN2_CONST = 64'd744261118;

  thin_plate_spline_3d_eval_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Shadow copy of the warp state, updated as each request is accepted.
  logic signed [31:0] cp_x [64];
  logic signed [31:0] cp_y [64];
  logic signed [31:0] cp_z [64];
  logic signed [31:0] cw_x [64];
  logic signed [31:0] cw_y [64];
  logic signed [31:0] cw_z [64];
  logic signed [31:0] affine [12];
  int unsigned        points_in_use;

  in_item_t  pending_q [$];
  out_item_t warped_q [$];

  int  mismatches;
  int  eval_count;
  int  load_count;
  int  result_count;
  int  send_gap;
  int  stall_left;
  int  hold_left;
  bit  burst_mode;
  bit  long_hold_req;
  bit  long_hold_seen;
  bit  hold_active;

  // Radial basis value 0.5 * r2 * ln(r2) in Q16.16 for one point offset.
  function automatic longint signed radial_term(longint signed dx, longint signed dy,
                                                longint signed dz);
    logic [63:0] ax, ay, az, r, m, frac, p, u;
    longint signed ln;
    int k, sh;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    r = ((ax * ax) >> 2) + ((ay * ay) >> 2) + ((az * az) >> 2);
    if (r <= R2_THRESH) return 0;
    k = 63;
    while (r[k] == 1'b0) k--;
    m = k >= 31 ? r >> (k - 31) : r << (31 - k);
    frac = 0;
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[29 - i] = 1'b1;
      end
    end
    m = k >= 31 ? r >> (k - 31) : r << (31 - k);
    ln = longint'(k - R2_SHIFT) * longint'(LN2_CONST) + longint'((frac * LN2_CONST) >> 30);
    p = (m >> 8) * (ln < 0 ? 64'(-ln) : 64'(ln));
    // The exponent k - 68 is always negative for a 64-bit r2.
    sh = 52 + FRAC_BITS - k;
    if (sh >= 64) u = 0;
    else u = (p + (64'd1 << (sh - 1))) >> sh;
    return ln < 0 ? -longint'(u) : longint'(u);
  endfunction

  function automatic logic signed [31:0] round_saturate(logic signed [127:0] acc);
    logic signed [127:0] q;
    q = (acc + 128'sd32768) >>> FRAC_BITS;
    if (q > SAT_HI) return 32'sh7FFF_FFFF;
    if (q < SAT_LO) return 32'sh8000_0000;
    return q[31:0];
  endfunction

  // Maps a query point through the affine rows plus, above four points, the radial sum.
  function automatic out_item_t warp_point(in_item_t it);
    out_item_t res;
    logic signed [127:0] acc, a, b;
    logic signed [31:0] q [3];
    logic signed [31:0] rowv [3];
    longint signed ut;
    int n;
    q[0] = it.coord_x;
    q[1] = it.coord_y;
    q[2] = it.coord_z;
    n = points_in_use > 64 ? 64 : points_in_use;
    for (int ax = 0; ax < 3; ax++) begin
      a = affine[ax * 4];
      acc = a <<< FRAC_BITS;
      for (int j = 0; j < 3; j++) begin
        a = affine[ax * 4 + 1 + j];
        b = q[j];
        acc += a * b;
      end
      if (n > RADIAL_MIN) begin
        for (int i = 0; i < n; i++) begin
          ut = radial_term(longint'(q[0]) - longint'(cp_x[i]),
                           longint'(q[1]) - longint'(cp_y[i]),
                           longint'(q[2]) - longint'(cp_z[i]));
          a = ut;
          b = ax == 0 ? cw_x[i] : (ax == 1 ? cw_y[i] : cw_z[i]);
          acc += a * b;
        end
      end
      rowv[ax] = round_saturate(acc);
    end
    res.mapped_x = rowv[0];
    res.mapped_y = rowv[1];
    res.mapped_z = rowv[2];
    return res;
  endfunction

  // Applies one accepted request to the shadow state.
  task automatic absorb_request(in_item_t it);
    case (it.opcode)
      OP_EVAL: begin
        warped_q.push_back(warp_point(it));
        eval_count++;
      end
      OP_POINT: begin
        cp_x[it.entry_index] = it.coord_x;
        cp_y[it.entry_index] = it.coord_y;
        cp_z[it.entry_index] = it.coord_z;
        cw_x[it.entry_index] = it.weight_x_in;
        cw_y[it.entry_index] = it.weight_y_in;
        cw_z[it.entry_index] = it.weight_z_in;
        load_count++;
      end
      OP_COEF: begin
        if (it.entry_index < COEF_COUNT) affine[it.entry_index] = it.coef_value;
        load_count++;
      end
      default: ;
    endcase
  endtask

  // Request driver: one random gap of idle cycles per request, none in burst mode.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) absorb_request(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
          send_gap = burst_mode ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps going meanwhile.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
      long_hold_seen = 1'b0;
      hold_active <= 1'b0;
    end else begin
      if (long_hold_req && !long_hold_seen) begin
        long_hold_seen = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) hold_left--;
      hold_active <= hold_left > 0;
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (warped_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          out_item_t want;
          want = warped_q.pop_front();
          if (want.mapped_x !== out_data.mapped_x || want.mapped_y !== out_data.mapped_y ||
              want.mapped_z !== out_data.mapped_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                       want.mapped_x, want.mapped_y, want.mapped_z,
                       out_data.mapped_x, out_data.mapped_y, out_data.mapped_z);
          end
        end
        stall_left = burst_mode ? 0 : $urandom_range(0, 7);
      end
      if (stall_left > 0) stall_left--;
      out_stall <= (stall_left > 0) || hold_active;
    end
  end

  // A field value: full range, extremes, or a small range that avoids saturation.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      2: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic in_item_t make_request(logic [1:0] op);
    in_item_t it;
    it.opcode      = op;
    it.entry_index = IDX_FIELD_W'($urandom_range(0, 63));
    it.coord_x     = pick_value();
    it.coord_y     = pick_value();
    it.coord_z     = pick_value();
    it.weight_x_in = pick_value();
    it.weight_y_in = pick_value();
    it.weight_z_in = pick_value();
    it.coef_value  = pick_value();
    return it;
  endfunction

  function automatic in_item_t coef_request(int idx, logic signed [31:0] val);
    in_item_t it;
    it = make_request(OP_COEF);
    it.entry_index = IDX_FIELD_W'(idx);
    it.coef_value = val;
    return it;
  endfunction

  function automatic in_item_t eval_request(logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [31:0] z);
    in_item_t it;
    it = make_request(OP_EVAL);
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    return it;
  endfunction

  // Waits until every queued request is taken and every result has come back.
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || warped_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the point count; only called while the block is idle.
  task automatic set_point_count(int unsigned n);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_POINT_COUNT;
    pwdata  <= n;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    points_in_use = n & 7'h7F;
  endtask

  // Random mix of evaluations, loads and requests the block ignores.
  task automatic random_phase(int count);
    in_item_t it;
    int sel;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 19);
      if (sel < 10) it = make_request(OP_EVAL);
      else if (sel < 15) it = make_request(OP_POINT);
      else if (sel < 18) begin
        it = make_request(OP_COEF);
        it.entry_index = IDX_FIELD_W'($urandom_range(0, COEF_COUNT - 1));
      end else if (sel == 18) it = make_request(OP_SPARE);
      else it = coef_request($urandom_range(COEF_COUNT, 63), pick_value());
      pending_q.push_back(it);
    end
  endtask

  initial begin
    in_item_t it;
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    eval_count = 0;
    load_count = 0;
    result_count = 0;
    burst_mode = 1'b0;
    long_hold_req = 1'b0;
    points_in_use = 0;
    foreach (affine[i]) affine[i] = 32'sd0;
    affine[1] = 32'sh0001_0000;
    affine[6] = 32'sh0001_0000;
    affine[11] = 32'sh0001_0000;
    foreach (cp_x[i]) begin
      cp_x[i] = 0; cp_y[i] = 0; cp_z[i] = 0;
      cw_x[i] = 0; cw_y[i] = 0; cw_z[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Pure affine map: identity after reset, then saturation both ways.
    set_point_count(0);
    pending_q.push_back(eval_request(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    pending_q.push_back(eval_request(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0));
    pending_q.push_back(coef_request(0, 32'sh7FFF_FFFF));
    pending_q.push_back(coef_request(1, 32'sh7FFF_FFFF));
    pending_q.push_back(coef_request(7, 32'sh8000_0000));
    pending_q.push_back(eval_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
    // Coefficient index past the last row and the spare opcode are ignored.
    pending_q.push_back(coef_request(12, 32'sh1234_5678));
    pending_q.push_back(coef_request(63, 32'sh8765_4321));
    pending_q.push_back(make_request(OP_SPARE));
    for (int i = 0; i < COEF_COUNT; i++)
      pending_q.push_back(coef_request(i, (i % 5 == 1) ? 32'sh0001_0000 : pick_value()));
    pending_q.push_back(eval_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    pending_q.push_back(eval_request(-32'sd1, 32'sd1, 32'sd0));

    // Fill every control point slot so no unwritten entry is ever read.
    for (int i = 0; i < 64; i++) begin
      it = make_request(OP_POINT);
      it.entry_index = IDX_FIELD_W'(i);
      it.coord_x = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      it.coord_y = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      it.coord_z = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      if (i == 0) begin
        it.coord_x = 32'sh0001_0000;
        it.coord_y = 32'sh0002_0000;
        it.coord_z = -32'sh0003_0000;
      end
      pending_q.push_back(it);
    end
    wait_quiet();

    // Radial terms: query on a control point, and just under and over the threshold.
    set_point_count(5);
    pending_q.push_back(eval_request(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000));
    pending_q.push_back(eval_request(32'sh0001_0006, 32'sh0002_0000, -32'sh0003_0000));
    pending_q.push_back(eval_request(32'sh0001_0007, 32'sh0002_0000, -32'sh0003_0000));
    random_phase(60);
    // The receiver holds off while the sender keeps offering requests.
    long_hold_req = 1'b1;
    random_phase(60);
    burst_mode = 1'b1;
    wait_quiet();

    set_point_count(8);
    random_phase(150);
    wait_quiet();

    set_point_count(64);
    for (int i = 0; i < 6; i++) pending_q.push_back(make_request(OP_EVAL));
    wait_quiet();

    set_point_count(4);
    random_phase(80);
    wait_quiet();

    set_point_count($urandom_range(5, 12));
    random_phase(120);
    wait_quiet();

    set_point_count(0);
    random_phase(80);
    wait_quiet();

    $display("run covered %0d evaluations and %0d table loads with point counts 0 to 64",
             eval_count, load_count);
    $display("%0d results checked, %0d mismatches", result_count, mismatches);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
